### src/lrs_pkg.sv
// Shared constants and control types for the replacement store.
package lrs_pkg;

    localparam int TICK_W    = 32;
    localparam int USES_W    = 16;
    localparam int CAP_W     = 7;
    localparam int FIELD_ID_W = 16;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [USES_W-1:0] USES_MAX = '1;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HELD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EVICT = 3'd4;

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } lrs_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic last_addr;
        logic out_free;
    } lrs_sts_t;

endpackage

### src/lrs_ctrl.sv
// Controller state machine that sequences the slot sweep and the final update.
module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  lrs_sts_t sts,
    output lrs_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = sts.fill_zero ? S_DECIDE : S_SWEEP;
                end
            end
            S_SWEEP: begin
                cmd.issue = 1'b1;
                if (sts.last_addr) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/lrs_datapath.sv
// Slot memory, sweep comparators, counters and result register.
module lrs_datapath
    import lrs_pkg::*;
#(
    parameter int SLOTS   = 64,
    parameter int ID_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   cfg_valid,
    input  logic [CAP_W-1:0]       cfg_data,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  lrs_cmd_t               cmd,
    output lrs_sts_t               sts
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW    = $clog2(SLOTS + 1);
    localparam int CW    = (FW > CAP_W) ? FW : CAP_W;
    localparam int ENT_W = ID_BITS + USES_W + TICK_W;

    logic [ENT_W-1:0] mem [SLOTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [ENT_W-1:0] wr_data;

    logic               op_reg, pol_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [AW-1:0]      addr_reg;
    logic               cmp_en_reg;
    logic [AW-1:0]      cmp_idx_reg;

    logic               hit_reg;
    logic [AW-1:0]      hit_idx_reg;
    logic [USES_W-1:0]  hit_uses_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [USES_W-1:0]  best_uses_reg;
    logic [TICK_W-1:0]  best_tick_reg;
    logic [ID_BITS-1:0] best_item_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [ID_BITS-1:0] rd_item;
    logic [USES_W-1:0]  rd_uses;
    logic [TICK_W-1:0]  rd_tick;
    logic               better;
    logic [CW-1:0]      cap_w, eff_cap;
    logic               has_free;
    logic [STATUS_W-1:0] status;
    logic [FIELD_ID_W-1:0] evicted;
    logic [USES_W-1:0]  uses_inc;

    assign {rd_item, rd_uses, rd_tick} = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Strict compares keep the lowest index on a full tie.
    always_comb begin
        if (cmp_idx_reg == '0) begin
            better = 1'b1;
        end else if (pol_reg && (rd_uses != best_uses_reg)) begin
            better = rd_uses < best_uses_reg;
        end else begin
            better = rd_tick < best_tick_reg;
        end
    end

    always_comb begin
        cap_w = CW'(cap_reg);
        if (cap_w == '0) begin
            eff_cap = CW'(1);
        end else if (cap_w > CW'(SLOTS)) begin
            eff_cap = CW'(SLOTS);
        end else begin
            eff_cap = cap_w;
        end
        has_free = CW'(fill_reg) < eff_cap;
        uses_inc = (hit_uses_reg == USES_MAX) ? hit_uses_reg : hit_uses_reg + 1'b1;

        mem_we    = 1'b0;
        wr_addr   = hit_idx_reg;
        wr_data   = {id_reg, uses_inc, tick_reg};
        status    = ST_MISS;
        evicted   = '0;
        fill_next = fill_reg;
        if (op_reg == OP_ACCESS) begin
            if (hit_reg) begin
                mem_we = cmd.finish;
                status = ST_HIT;
            end
        end else if (hit_reg) begin
            status = ST_HELD;
        end else begin
            mem_we  = cmd.finish;
            wr_data = {id_reg, {USES_W{1'b0}}, tick_reg};
            if (has_free || (fill_reg == '0)) begin
                wr_addr   = AW'(fill_reg);
                status    = ST_FREE;
                fill_next = fill_reg + 1'b1;
            end else begin
                wr_addr = best_idx_reg;
                status  = ST_EVICT;
                evicted = FIELD_ID_W'(best_item_reg);
            end
        end
        m_tdata_next = M_TDATA_W'({evicted, status});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            fill_reg     <= '0;
            cap_reg      <= CAP_W'(64);
            cmp_en_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            addr_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            cmp_en_reg <= cmd.issue;
            if (cmd.start) begin
                tick_reg <= tick_reg + 1'b1;
                hit_reg  <= 1'b0;
                addr_reg <= '0;
            end else if (cmd.issue) begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmp_en_reg && (rd_item == id_reg)) begin
                hit_reg <= 1'b1;
            end
            if (cmd.finish) begin
                fill_reg     <= fill_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= s_tdata[0];
            id_reg  <= ID_BITS'(s_tdata[FIELD_ID_W:1]);
            pol_reg <= s_tdata[FIELD_ID_W+1];
        end
        cmp_idx_reg <= addr_reg;
        if (cmp_en_reg && (rd_item == id_reg)) begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_uses_reg <= rd_uses;
        end
        if (cmp_en_reg && better) begin
            best_idx_reg  <= cmp_idx_reg;
            best_uses_reg <= rd_uses;
            best_tick_reg <= rd_tick;
            best_item_reg <= rd_item;
        end
        if (cmd.finish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign sts.fill_zero = (fill_reg == '0);
    assign sts.last_addr = (FW'(addr_reg) + 1'b1) == fill_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

### src/lru_lfu_replacement_store.sv
// Top level of the LRU/LFU replacement store.
//
// Channel   Direction  Handshake            Contents
// s_        in         s_tvalid / s_tready  one access or insert per transaction
// m_        out        m_tvalid / m_tready  one status result per transaction
// cfg_      in         cfg_valid/cfg_ready  capacity register write
//
// An accepted item sweeps the single read port of the slot memory over every
// occupied slot, drains the registered read, and then decides and writes back,
// with its result loaded once the output register is free. An empty store
// skips the sweep and the drain.
// Reset is synchronous on aresetn; the slot memory needs no clearing pass,
// because occupied slots always form the range below the fill level.
// A stalled result waits in the output register; the next item is accepted
// meanwhile, and only its write-back waits for the register to free up.
module lru_lfu_replacement_store
    import lrs_pkg::*;
#(
    parameter int SLOTS   = 64,
    parameter int ID_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: op[0], item_id[16:1], policy[17], zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: status[2:0], evicted_id[18:3], zero fill.
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CAP_W-1:0]     cfg_data
);

    lrs_cmd_t cmd;
    lrs_sts_t sts;

    // The capacity register is always ready to take a write.
    assign cfg_ready = 1'b1;

    lrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrs_datapath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### src/lrs_checker.sv
// Port-level checker for the replacement store and its bind.
module lrs_checker
    import lrs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == ST_HIT) || (m_tdata[2:0] == ST_MISS) ||
        (m_tdata[2:0] == ST_FREE) || (m_tdata[2:0] == ST_HELD) ||
        (m_tdata[2:0] == ST_EVICT))
        else $error("status code out of range");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_EVICT) |-> m_tdata[18:3] == '0)
        else $error("evicted id set without an eviction");

endmodule

bind lru_lfu_replacement_store lrs_checker u_lrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/lru_lfu_replacement_store_tb.sv
// Self-checking testbench for the LRU/LFU replacement store, with directed and random traffic.
module lru_lfu_replacement_store_tb;
    import lrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT   = 64;
    localparam int LIMIT   = 2_000_000;
    localparam int ID_ANY  = -1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // Fields from bit 0: op[0], item_id[16:1], policy[17], zero fill.
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // Fields from bit 0: status[2:0], evicted_id[18:3], zero fill.
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data;

    lru_lfu_replacement_store #(.SLOTS(NSLOT), .ID_BITS(FIELD_ID_W)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the store used to predict every status result.
    logic                  sh_valid [NSLOT];
    logic [FIELD_ID_W-1:0] sh_item  [NSLOT];
    logic [USES_W-1:0]     sh_uses  [NSLOT];
    logic [TICK_W-1:0]     sh_tick  [NSLOT];
    logic [TICK_W-1:0]     sh_now;
    int unsigned           sh_fill;
    logic [CAP_W-1:0]      sh_cap;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [FIELD_ID_W-1:0] evicted;
    } lookup_result_t;

    lookup_result_t pending_results[$];

    int  error_count;
    int  cycle_count;
    int  hold_off;      // cycles of forced receiver stall, counted down below
    int  send_idle_pct;
    int  recv_stall_pct;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Computes the result of one event and advances the shadow store.
    function automatic lookup_result_t store_event(input logic op,
                                                   input logic [FIELD_ID_W-1:0] id,
                                                   input logic lfu);
        lookup_result_t r;
        int hit, slot, victim;
        int unsigned cap;
        r.status = ST_MISS;
        r.evicted = '0;
        hit = -1;
        slot = -1;
        victim = -1;
        cap = (sh_cap == 0) ? 1 : ((sh_cap > NSLOT) ? NSLOT : sh_cap);
        sh_now = sh_now + 1;
        for (int k = 0; k < NSLOT; k++)
            if (hit < 0 && sh_valid[k] && sh_item[k] == id) hit = k;
        if (op == OP_ACCESS) begin
            if (hit >= 0) begin
                if (sh_uses[hit] != USES_MAX) sh_uses[hit] = sh_uses[hit] + 1'b1;
                sh_tick[hit] = sh_now;
                r.status = ST_HIT;
            end
        end else if (hit >= 0) begin
            r.status = ST_HELD;
        end else begin
            if (sh_fill < cap)
                for (int k = 0; k < NSLOT; k++)
                    if (slot < 0 && !sh_valid[k]) slot = k;
            if (slot >= 0) begin
                sh_fill++;
                r.status = ST_FREE;
            end else begin
                for (int k = 0; k < NSLOT; k++) begin
                    if (!sh_valid[k]) continue;
                    if (victim < 0) victim = k;
                    else if (lfu && sh_uses[k] != sh_uses[victim]) begin
                        if (sh_uses[k] < sh_uses[victim]) victim = k;
                    end else if (sh_tick[k] < sh_tick[victim]) victim = k;
                end
                slot = victim;
                r.status = ST_EVICT;
                r.evicted = sh_item[slot];
            end
            sh_valid[slot] = 1'b1;
            sh_item[slot] = id;
            sh_uses[slot] = '0;
            sh_tick[slot] = sh_now;
        end
        return r;
    endfunction

    // Cycle counter and timeout guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("lru_lfu_replacement_store_tb: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long forced hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every result transaction is compared with the oldest expectation.
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result status", m_tdata[2:0], ID_ANY);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", m_tdata[2:0], want.status);
                if (m_tdata[18:3] !== want.evicted)
                    report_mismatch("evicted_id", m_tdata[18:3], want.evicted);
                if (m_tdata[M_TDATA_W-1:19] !== '0)
                    report_mismatch("result fill bits", m_tdata[M_TDATA_W-1:19], 0);
            end
        end
    end

    // Sends one item; the prediction is queued when the transaction is accepted.
    // Valid stays high after acceptance; the next call either offers a new item
    // at once or drops valid while it idles.
    // A negative check value means the predictor alone decides the result.
    task automatic send_item(input logic op, input logic [FIELD_ID_W-1:0] id,
                             input logic lfu, input int want_status, input int want_evict);
        lookup_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, lfu, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = store_event(op, id, lfu);
        if (want_status >= 0 && r.status != want_status)
            report_mismatch("directed status", r.status, want_status);
        if (want_evict >= 0 && r.evicted != want_evict)
            report_mismatch("directed evicted_id", r.evicted, want_evict);
        pending_results.push_back(r);
    endtask

    // Waits for all results, then lets the pipeline drain before touching config.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NSLOT + 8) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sh_cap = value;
    endtask

    typedef struct {
        logic op;
        int   id;
        logic lfu;
        int   status;
        int   evict;
    } stim_row_t;

    // Directed rows: fill a small store, hit, miss, held insert, evictions under both rules.
    stim_row_t directed[] = '{
        '{OP_ACCESS, 16'h0000, 1'b0, ST_MISS,  0},
        '{OP_INSERT, 16'hFFFF, 1'b1, ST_FREE,  0},
        '{OP_INSERT, 16'h0000, 1'b0, ST_FREE,  0},
        '{OP_INSERT, 16'h5A5A, 1'b0, ST_FREE,  0},
        '{OP_INSERT, 16'hFFFF, 1'b0, ST_HELD,  0},
        '{OP_ACCESS, 16'hFFFF, 1'b1, ST_HIT,   0},
        '{OP_ACCESS, 16'hFFFF, 1'b0, ST_HIT,   0},
        '{OP_ACCESS, 16'h0000, 1'b0, ST_HIT,   0},
        '{OP_ACCESS, 16'hA5A5, 1'b0, ST_MISS,  0},
        '{OP_INSERT, 16'h1234, 1'b0, ST_EVICT, 16'h5A5A},
        '{OP_INSERT, 16'h4321, 1'b1, ST_EVICT, 16'h1234},
        '{OP_INSERT, 16'h8001, 1'b0, -1, -1},
        '{OP_ACCESS, 16'h4321, 1'b1, -1, -1},
        '{OP_INSERT, 16'h7FFE, 1'b1, -1, -1},
        '{OP_ACCESS, 16'h7FFE, 1'b0, -1, -1}
    };

    int unsigned id_pool_size;

    task automatic random_phase(input int count, input int idle, input int stall);
        logic [FIELD_ID_W-1:0] id;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            // Ids mostly come from a small pool so hits and evictions happen often.
            if ($urandom_range(9) == 0) id = FIELD_ID_W'($urandom);
            else id = FIELD_ID_W'($urandom_range(id_pool_size));
            send_item(1'($urandom_range(1)), id, 1'($urandom_range(1)), -1, -1);
        end
        send_idle_pct = 0;
    endtask

    initial begin
        logic [CAP_W-1:0] caps[] = '{7'd4, 7'd0, 7'd1, 7'd64, 7'd127, 7'd17, 7'd2};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        id_pool_size = 15;
        for (int k = 0; k < NSLOT; k++) begin
            sh_valid[k] = 1'b0;
            sh_item[k] = '0;
            sh_uses[k] = '0;
            sh_tick[k] = '0;
        end
        sh_now = '0;
        sh_fill = 0;
        sh_cap = 7'd64;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Capacity three for the directed part.
        write_capacity(7'd3);
        foreach (directed[i])
            send_item(directed[i].op, directed[i].id[FIELD_ID_W-1:0], directed[i].lfu,
                      directed[i].status, directed[i].evict);
        drain_results();

        // Random phases over several capacities and idle patterns.
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            id_pool_size = (caps[c] > 20) ? 90 : 3 * caps[c] + 3;
            random_phase(40, 0, 0);
            random_phase(40, 72, 0);
            random_phase(40, 0, 72);
            random_phase(40, 11, 11);
            drain_results();
        end

        // Lower capacity under a full store, so inserts keep evicting.
        write_capacity(7'd5);
        id_pool_size = 40;
        random_phase(100, 0, 30);

        // Long receiver hold-off while the sender keeps offering items.
        hold_off = 300;
        random_phase(60, 0, 0);
        drain_results();

        // Repeated accesses to one slot, then inserts that evict under the frequency rule.
        write_capacity(7'd2);
        send_item(OP_INSERT, 16'hBEEF, 1'b0, -1, -1);
        recv_stall_pct = 0;
        for (int n = 0; n < 20; n++) send_item(OP_ACCESS, 16'hBEEF, 1'b1, ST_HIT, 0);
        send_item(OP_INSERT, 16'h0101, 1'b1, -1, -1);
        send_item(OP_INSERT, 16'h0202, 1'b1, -1, -1);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (NSLOT + 8) @(posedge aclk);
        if (error_count == 0) begin
            $display("lru_lfu_replacement_store_tb: clean");
        end else begin
            $display("lru_lfu_replacement_store_tb: errors");
        end
        $finish;
    end

endmodule
